[rtl/core/pla_pkg.sv]
// Package for the positional list array.
// Holds the controller state type, operation codes and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pla_pkg;

	localparam logic [2:0] OP_INSERT   = 3'd0;
	localparam logic [2:0] OP_REMOVE   = 3'd1;
	localparam logic [2:0] OP_RETRIEVE = 3'd2;
	localparam logic [2:0] OP_REPLACE  = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	localparam int RESULT_WIDTH = 32;
	localparam int COUNT_WIDTH  = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CAPTURE,
		ST_SH_RD,
		ST_SH_WR,
		ST_PLACE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_req;
		logic idx_from_fill;
		logic idx_from_pos;
		logic idx_dec;
		logic idx_inc;
		logic mem_rd;
		logic rd_shift;
		logic mem_wr;
		logic wr_shift;
		logic cap_item;
		logic set_ok;
		logic fill_inc;
		logic fill_dec;
		logic fill_clr;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       ins_ok;
		logic       ins_at_end;
		logic       pos_ok;
		logic       rem_tail;
		logic       up_last;
		logic       down_last;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/pla_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pla_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/pla_ctrl.sv]
// Controller state machine for the positional list array.
// Sequences decode, entry shifting and result hand-off; uses pla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pla_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire pla_pkg::sts_t sts,
	output pla_pkg::cmd_t      cmd
);

	pla_pkg::state_t state_q;
	pla_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pla_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			pla_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = pla_pkg::ST_DECODE;
				end
			end
			pla_pkg::ST_DECODE: begin
				state_d = pla_pkg::ST_DONE;
				case (sts.op)
					pla_pkg::OP_INSERT: begin
						if (sts.ins_ok) begin
							if (sts.ins_at_end) begin
								state_d = pla_pkg::ST_PLACE;
							end else begin
								cmd.idx_from_fill = 1'b1;
								state_d           = pla_pkg::ST_SH_RD;
							end
						end
					end
					pla_pkg::OP_REMOVE, pla_pkg::OP_RETRIEVE: begin
						if (sts.pos_ok) begin
							cmd.mem_rd = 1'b1;
							state_d    = pla_pkg::ST_CAPTURE;
						end
					end
					pla_pkg::OP_REPLACE: begin
						if (sts.pos_ok) begin
							cmd.mem_wr = 1'b1;
							cmd.set_ok = 1'b1;
						end
					end
					pla_pkg::OP_CLEAR: begin
						cmd.fill_clr = 1'b1;
						cmd.set_ok   = 1'b1;
					end
					default: begin
						state_d = pla_pkg::ST_DONE;
					end
				endcase
			end
			pla_pkg::ST_CAPTURE: begin
				cmd.cap_item = 1'b1;
				cmd.set_ok   = 1'b1;
				state_d      = pla_pkg::ST_DONE;
				if (sts.op == pla_pkg::OP_REMOVE) begin
					if (sts.rem_tail) begin
						cmd.idx_from_pos = 1'b1;
						state_d          = pla_pkg::ST_SH_RD;
					end else begin
						cmd.fill_dec = 1'b1;
					end
				end
			end
			pla_pkg::ST_SH_RD: begin
				cmd.mem_rd   = 1'b1;
				cmd.rd_shift = 1'b1;
				state_d      = pla_pkg::ST_SH_WR;
			end
			pla_pkg::ST_SH_WR: begin
				cmd.mem_wr   = 1'b1;
				cmd.wr_shift = 1'b1;
				if (sts.op == pla_pkg::OP_INSERT) begin
					if (sts.up_last) begin
						state_d = pla_pkg::ST_PLACE;
					end else begin
						cmd.idx_dec = 1'b1;
						state_d     = pla_pkg::ST_SH_RD;
					end
				end else begin
					if (sts.down_last) begin
						cmd.fill_dec = 1'b1;
						state_d      = pla_pkg::ST_DONE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = pla_pkg::ST_SH_RD;
					end
				end
			end
			pla_pkg::ST_PLACE: begin
				cmd.mem_wr   = 1'b1;
				cmd.fill_inc = 1'b1;
				cmd.set_ok   = 1'b1;
				state_d      = pla_pkg::ST_DONE;
			end
			pla_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = pla_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pla_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/pla_dp.sv]
// Datapath for the positional list array: request, count, cursor and result registers
// plus the entry RAM. Uses pla_pkg and pla_ram.
`timescale 1ns / 1ps
`default_nettype none

module pla_dp #(
	parameter int CAPACITY    = 128,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [2:0]    req_type,
	input  wire logic [7:0]    position,
	input  wire logic [31:0]   item_value,
	input  wire pla_pkg::cmd_t cmd,
	output pla_pkg::sts_t      sts,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               ok,
	output logic [31:0]        item_out,
	output logic [7:0]         entry_count,
	output logic               is_empty,
	output logic               is_full
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 8) ? CW : 8;

	logic [2:0]             op_q;
	logic [PW-1:0]          pos_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          idx_q;
	logic                   ok_q;
	logic [31:0]            item_q;
	logic                   out_valid_q;

	logic [VALUE_WIDTH-1:0] in_val;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic [31:0]            rd_ext;
	logic [PW:0]            fill_w;
	logic [PW:0]            pos_w;
	logic [PW:0]            idx_w;
	logic [CW-1:0]          idx_src;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic [PW-1:0]          count_w;

	generate
		if (VALUE_WIDTH <= 32) begin : g_narrow
			assign in_val = item_value[VALUE_WIDTH-1:0];
		end else begin : g_wide
			assign in_val = {{(VALUE_WIDTH-32){item_value[31]}}, item_value};
		end
		if (VALUE_WIDTH >= 32) begin : g_rd_trunc
			assign rd_ext = rd_data[31:0];
		end else begin : g_rd_sext
			assign rd_ext = {{(32-VALUE_WIDTH){rd_data[VALUE_WIDTH-1]}}, rd_data};
		end
	endgenerate

	assign fill_w = (PW + 1)'(fill_q);
	assign pos_w  = (PW + 1)'(pos_q);
	assign idx_w  = (PW + 1)'(idx_q);

	assign sts.op         = op_q;
	assign sts.ins_ok     = (fill_q != CW'(CAPACITY)) && (pos_w <= fill_w);
	assign sts.ins_at_end = (pos_w == fill_w);
	assign sts.pos_ok     = (pos_w < fill_w);
	assign sts.rem_tail   = ((pos_w + (PW + 1)'(1)) < fill_w);
	assign sts.up_last    = (idx_w == (pos_w + (PW + 1)'(1)));
	assign sts.down_last  = ((idx_w + (PW + 1)'(2)) >= fill_w);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign idx_src = (op_q == pla_pkg::OP_INSERT) ? (idx_q - CW'(1)) : (idx_q + CW'(1));
	assign rd_en   = cmd.mem_rd;
	assign rd_addr = cmd.rd_shift ? idx_src[AW-1:0] : pos_q[AW-1:0];
	assign wr_en   = cmd.mem_wr;
	assign wr_addr = cmd.wr_shift ? idx_q[AW-1:0] : pos_q[AW-1:0];
	assign wr_data = cmd.wr_shift ? rd_data : val_q;

	pla_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fill_clr) begin
				fill_q <= '0;
			end else if (cmd.fill_inc) begin
				fill_q <= fill_q + CW'(1);
			end else if (cmd.fill_dec) begin
				fill_q <= fill_q - CW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q   <= req_type;
			pos_q  <= PW'(position);
			val_q  <= in_val;
			ok_q   <= 1'b0;
			item_q <= '0;
		end else begin
			if (cmd.set_ok) begin
				ok_q <= 1'b1;
			end
			if (cmd.cap_item) begin
				item_q <= rd_ext;
			end
		end
		if (cmd.idx_from_fill) begin
			idx_q <= fill_q;
		end else if (cmd.idx_from_pos) begin
			idx_q <= pos_q[CW-1:0];
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - CW'(1);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	assign count_w = PW'(fill_q);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			ok          <= ok_q;
			item_out    <= item_q;
			entry_count <= count_w[7:0];
			is_empty    <= (fill_q == '0);
			is_full     <= (fill_q == CW'(CAPACITY));
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/positional_list_array.sv]
// Positional list array: one request in, one result transaction out.
// Replace, clear and rejected requests need no RAM read; retrieve and remove read the entry;
// insert shifts the entries at and above the position up, remove those above it down.
// One request at a time: each shifted entry takes a RAM read state and a RAM write state.
// Reset clears the entry count and the output valid; entry storage is not cleared.
// Top level: joins pla_ctrl and pla_dp, uses pla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_array #(
	parameter int CAPACITY    = 128,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  req_type,
	input  wire logic [7:0]  position,
	input  wire logic [31:0] item_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ok,
	output logic [31:0]      item_out,
	output logic [7:0]       entry_count,
	output logic             is_empty,
	output logic             is_full
);

	pla_pkg::cmd_t cmd;
	pla_pkg::sts_t sts;

	pla_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	pla_dp #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req_type),
		.position   (position),
		.item_value (item_value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.item_out   (item_out),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

endmodule

`default_nettype wire
